@@ design/rrts_pkg.sv @@
package rrts_pkg;

    localparam int MAX_THREADS = 16;
    localparam int MAX_SEMS    = 8;
    localparam int TID_W       = 4;
    localparam int SID_W       = 3;
    localparam int WQ_AW       = SID_W + TID_W;
    localparam int STACK_LIMIT = 16384;
    localparam int COUNT_TOP   = 127;
    localparam logic [19:0] QUANTUM_RESET = 20'd1000;

    typedef enum logic [3:0] {
        OP_START   = 4'd0,
        OP_TICK    = 4'd1,
        OP_CREATE  = 4'd2,
        OP_EXIT    = 4'd3,
        OP_SEM_NEW = 4'd4,
        OP_WAIT    = 4'd5,
        OP_SIGNAL  = 4'd6,
        OP_DESTROY = 4'd7,
        OP_QUERY   = 4'd8,
        OP_BAD     = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        TS_UNUSED = 2'd0,
        TS_READY  = 2'd1,
        TS_WAIT   = 2'd2,
        TS_EXIT   = 2'd3
    } ts_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REFUSED  = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_EMPTY    = 2'd3
    } st_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_RESCHED,
        BK_SETRUN,
        BK_SIGPOP
    } bk_state_t;

    typedef struct packed {
        op_t                op;
        logic               big_stack;
        logic [SID_W-1:0]   sem_index;
        logic [6:0]         init;
    } req_t;

    typedef struct packed {
        st_t                status;
        logic [TID_W-1:0]   tid;
        logic [SID_W-1:0]   sid;
        logic signed [7:0]  count;
        logic [TID_W-1:0]   running;
        logic               switched;
    } res_t;

endpackage

@@ design/round_robin_thread_scheduler.sv @@
// Round-robin thread scheduler with counting semaphores. Requests enter a
// two-entry queue that is free of the execution engine, so one request can be
// taken while the previous result waits. Each request yields one result.
// Steps per request: most requests go dequeue, execute, result; a signal that
// wakes a waiter adds a step because the wait-queue memory read is registered;
// start, exit, blocking wait and quantum expiry go through the reschedule
// sequencer, which drops one exited run-queue entry per cycle and adds a
// rotation step on quantum expiry; at most 14 threads exist.
// quantum_ticks sits at byte address 0 of the APB port and resets to 1000.
module round_robin_thread_scheduler
    import rrts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [3:0]        req_type,
    input  logic [15:0]       stack_size,
    input  logic [2:0]        sem_index,
    input  logic [6:0]        sem_init_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [3:0]        new_thread_id,
    output logic [2:0]        new_sem_id,
    output logic signed [7:0] sem_count,
    output logic [3:0]        running_thread,
    output logic              switched
);

    logic [19:0] quantum_reg;
    logic        q_valid, q_pop;
    req_t        q_req;
    res_t        res;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {12'd0, quantum_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quantum_reg <= QUANTUM_RESET;
        else if (psel && penable && pwrite && pready)
            quantum_reg <= pwdata[19:0];
    end

    rrts_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .stack_size     (stack_size),
        .sem_index      (sem_index),
        .sem_init_value (sem_init_value),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_req          (q_req)
    );

    rrts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .quantum   (quantum_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_req     (q_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign status         = res.status;
    assign new_thread_id  = res.tid;
    assign new_sem_id     = res.sid;
    assign sem_count      = res.count;
    assign running_thread = res.running;
    assign switched       = res.switched;

endmodule

@@ design/rrts_front.sv @@
module rrts_front
    import rrts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  req_type,
    input  logic [15:0] stack_size,
    input  logic [2:0]  sem_index,
    input  logic [6:0]  sem_init_value,
    output logic        q_valid,
    input  logic        q_pop,
    output req_t        q_req
);

    req_t       buf_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    req_t       dec;
    logic       push;

    always_comb
    begin
        dec.op        = (req_type > 4'(OP_QUERY)) ? OP_BAD : op_t'(req_type);
        dec.big_stack = ({16'd0, stack_size} > 32'(STACK_LIMIT));
        dec.sem_index = sem_index;
        dec.init      = sem_init_value;
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = buf_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

@@ design/rrts_back.sv @@
module rrts_back
    import rrts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [19:0] quantum,
    input  logic        q_valid,
    output logic        q_pop,
    input  req_t        q_req,
    output logic        out_valid,
    input  logic        out_ready,
    output res_t        res
);

    bk_state_t state_reg, state_next;
    req_t      cur_reg, cur_next;
    logic [TID_W-1:0] before_reg, before_next;
    logic      rotate_reg, rotate_next;
    st_t       st_reg, st_next;
    logic [TID_W-1:0] tid_reg, tid_next;
    logic [SID_W-1:0] sid_reg, sid_next;
    logic signed [7:0] co_reg, co_next;
    logic      out_valid_reg, out_valid_next;
    res_t      res_reg, res_next;

    logic [TID_W-1:0] rq_reg [MAX_THREADS];
    logic [TID_W-1:0] rq_next [MAX_THREADS];
    logic [TID_W-1:0] rq_head_reg, rq_head_next;
    logic [TID_W:0]   rq_count_reg, rq_count_next;
    ts_t       ts_reg [MAX_THREADS];
    ts_t       ts_next [MAX_THREADS];
    logic [TID_W-1:0] running_reg, running_next;
    logic [TID_W:0]   ntn_reg, ntn_next;
    logic signed [7:0] cnt_reg [MAX_SEMS];
    logic signed [7:0] cnt_next [MAX_SEMS];
    logic [6:0] init_reg [MAX_SEMS];
    logic [6:0] init_next [MAX_SEMS];
    logic [MAX_SEMS-1:0] sv_reg, sv_next;
    logic [SID_W:0] nsn_reg, nsn_next;
    logic [TID_W-1:0] wqh_reg [MAX_SEMS];
    logic [TID_W-1:0] wqh_next [MAX_SEMS];
    logic [TID_W:0]   wqc_reg [MAX_SEMS];
    logic [TID_W:0]   wqc_next [MAX_SEMS];
    logic [19:0] sc_reg, sc_next;
    logic      started_reg, started_next;

    logic [TID_W-1:0] wq_mem [MAX_THREADS*MAX_SEMS];
    logic             wq_we;
    logic [WQ_AW-1:0] wq_waddr, wq_raddr;
    logic [TID_W-1:0] wq_wdata, wq_rd_reg;

    logic [TID_W-1:0] tail, head_id;
    logic [SID_W-1:0] si;
    logic signed [7:0] c, cn;
    logic [20:0] sc1;
    logic        fin;

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        before_next   = before_reg;
        rotate_next   = rotate_reg;
        st_next       = st_reg;
        tid_next      = tid_reg;
        sid_next      = sid_reg;
        co_next       = co_reg;
        out_valid_next = out_valid_reg;
        res_next      = res_reg;
        rq_next       = rq_reg;
        rq_head_next  = rq_head_reg;
        rq_count_next = rq_count_reg;
        ts_next       = ts_reg;
        running_next  = running_reg;
        ntn_next      = ntn_reg;
        cnt_next      = cnt_reg;
        init_next     = init_reg;
        sv_next       = sv_reg;
        nsn_next      = nsn_reg;
        wqh_next      = wqh_reg;
        wqc_next      = wqc_reg;
        sc_next       = sc_reg;
        started_next  = started_reg;
        q_pop         = 1'b0;
        wq_we         = 1'b0;
        wq_waddr      = '0;
        wq_wdata      = running_reg;
        wq_raddr      = '0;
        fin           = 1'b0;

        tail    = rq_head_reg + rq_count_reg[TID_W-1:0];
        head_id = rq_reg[rq_head_reg];
        si      = cur_reg.sem_index;
        c       = cnt_reg[si];
        cn      = c + 8'sd1;
        sc1     = {1'b0, sc_reg} + 21'd1;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (out_valid_reg && out_ready)
                    out_valid_next = 1'b0;
                if (q_valid && (!out_valid_reg || out_ready))
                begin
                    q_pop       = 1'b1;
                    cur_next    = q_req;
                    before_next = running_reg;
                    st_next     = ST_OK;
                    tid_next    = '0;
                    sid_next    = '0;
                    co_next     = '0;
                    rotate_next = 1'b0;
                    state_next  = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                fin = 1'b1;
                case (cur_reg.op)
                    OP_START:
                    begin
                        if (started_reg)
                            st_next = ST_REFUSED;
                        else
                        begin
                            started_next = 1'b1;
                            sc_next      = '0;
                            fin          = 1'b0;
                            state_next   = BK_RESCHED;
                        end
                    end
                    OP_TICK:
                    begin
                        if (started_reg)
                        begin
                            if (sc1 >= {1'b0, quantum})
                            begin
                                sc_next     = '0;
                                rotate_next = 1'b1;
                                fin         = 1'b0;
                                state_next  = BK_RESCHED;
                            end
                            else
                                sc_next = sc1[19:0];
                        end
                    end
                    OP_CREATE:
                    begin
                        if (cur_reg.big_stack || ntn_reg >= (TID_W+1)'(MAX_THREADS-1)
                            || rq_count_reg >= (TID_W+1)'(MAX_THREADS))
                            st_next = ST_REFUSED;
                        else
                        begin
                            ntn_next      = ntn_reg + 1'b1;
                            tid_next      = ntn_next[TID_W-1:0];
                            ts_next[tid_next] = TS_READY;
                            rq_next[tail] = tid_next;
                            rq_count_next = rq_count_reg + 1'b1;
                        end
                    end
                    OP_EXIT:
                    begin
                        if (running_reg == '0)
                            st_next = ST_REFUSED;
                        else
                        begin
                            ts_next[running_reg] = TS_EXIT;
                            fin        = 1'b0;
                            state_next = BK_RESCHED;
                        end
                    end
                    OP_SEM_NEW:
                    begin
                        if (nsn_reg >= (SID_W+1)'(MAX_SEMS))
                            st_next = ST_REFUSED;
                        else
                        begin
                            sid_next            = nsn_reg[SID_W-1:0];
                            nsn_next            = nsn_reg + 1'b1;
                            sv_next[sid_next]   = 1'b1;
                            cnt_next[sid_next]  = $signed({1'b0, cur_reg.init});
                            init_next[sid_next] = cur_reg.init;
                            wqh_next[sid_next]  = '0;
                            wqc_next[sid_next]  = '0;
                            co_next             = $signed({1'b0, cur_reg.init});
                        end
                    end
                    OP_WAIT:
                    begin
                        if (!sv_reg[si])
                            st_next = ST_REFUSED;
                        else if (c > 8'sd0)
                        begin
                            cnt_next[si] = c - 8'sd1;
                            co_next      = c - 8'sd1;
                        end
                        else if (running_reg == '0
                                 || wqc_reg[si] >= (TID_W+1)'(MAX_THREADS))
                        begin
                            st_next = ST_REFUSED;
                            co_next = c;
                        end
                        else
                        begin
                            cnt_next[si] = c - 8'sd1;
                            co_next      = c - 8'sd1;
                            wq_we        = 1'b1;
                            wq_waddr     = {si, wqh_reg[si] + wqc_reg[si][TID_W-1:0]};
                            wqc_next[si] = wqc_reg[si] + 1'b1;
                            ts_next[running_reg] = TS_WAIT;
                            if (rq_count_reg != '0 && head_id == running_reg)
                            begin
                                rq_head_next  = rq_head_reg + 1'b1;
                                rq_count_next = rq_count_reg - 1'b1;
                            end
                            fin        = 1'b0;
                            state_next = BK_RESCHED;
                        end
                    end
                    OP_SIGNAL:
                    begin
                        if (!sv_reg[si])
                            st_next = ST_REFUSED;
                        else if (c >= 8'sd127)
                        begin
                            st_next = ST_REFUSED;
                            co_next = c;
                        end
                        else
                        begin
                            cnt_next[si] = cn;
                            co_next      = cn;
                            if (cn <= 8'sd0 && wqc_reg[si] != '0
                                && rq_count_reg < (TID_W+1)'(MAX_THREADS))
                            begin
                                wq_raddr   = {si, wqh_reg[si]};
                                fin        = 1'b0;
                                state_next = BK_SIGPOP;
                            end
                        end
                    end
                    OP_DESTROY:
                    begin
                        if (!sv_reg[si])
                            st_next = ST_REFUSED;
                        else
                        begin
                            co_next = c;
                            if (wqc_reg[si] != '0)
                                st_next = ST_REFUSED;
                            else
                            begin
                                if (c != $signed({1'b0, init_reg[si]}))
                                    st_next = ST_MISMATCH;
                                sv_next[si]   = 1'b0;
                                cnt_next[si]  = '0;
                                init_next[si] = '0;
                            end
                        end
                    end
                    OP_QUERY:
                    begin
                        if (!sv_reg[si])
                            st_next = ST_REFUSED;
                        else
                            co_next = c;
                    end
                    default:
                        st_next = ST_REFUSED;
                endcase
            end
            BK_RESCHED:
            begin
                // one exited entry dropped from the front per cycle
                if (rq_count_reg != '0 && ts_reg[head_id] == TS_EXIT)
                begin
                    rq_head_next  = rq_head_reg + 1'b1;
                    rq_count_next = rq_count_reg - 1'b1;
                end
                else if (rq_count_reg == '0)
                begin
                    running_next = '0;
                    if (cur_reg.op == OP_START)
                        st_next = ST_EMPTY;
                    fin = 1'b1;
                end
                else if (rotate_reg)
                begin
                    rq_next[tail] = head_id;
                    rq_head_next  = rq_head_reg + 1'b1;
                    state_next    = BK_SETRUN;
                end
                else
                begin
                    running_next = head_id;
                    fin = 1'b1;
                end
            end
            BK_SETRUN:
            begin
                running_next = head_id;
                fin = 1'b1;
            end
            BK_SIGPOP:
            begin
                wqh_next[si]  = wqh_reg[si] + 1'b1;
                wqc_next[si]  = wqc_reg[si] - 1'b1;
                ts_next[wq_rd_reg] = TS_READY;
                rq_next[tail] = wq_rd_reg;
                rq_count_next = rq_count_reg + 1'b1;
                fin = 1'b1;
            end
            default:
                state_next = BK_IDLE;
        endcase

        if (fin)
        begin
            state_next     = BK_IDLE;
            out_valid_next = 1'b1;
            res_next.status   = st_next;
            res_next.tid      = tid_next;
            res_next.sid      = sid_next;
            res_next.count    = co_next;
            res_next.running  = running_next;
            res_next.switched = (running_next != before_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wq_we)
            wq_mem[wq_waddr] <= wq_wdata;
        wq_rd_reg <= wq_mem[wq_raddr];
    end

    always_ff @(posedge clk)
    begin
        rq_reg     <= rq_next;
        cur_reg    <= cur_next;
        before_reg <= before_next;
        rotate_reg <= rotate_next;
        st_reg     <= st_next;
        tid_reg    <= tid_next;
        sid_reg    <= sid_next;
        co_reg     <= co_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            rq_head_reg   <= '0;
            rq_count_reg  <= '0;
            running_reg   <= '0;
            ntn_reg       <= (TID_W+1)'(1);
            sv_reg        <= '0;
            nsn_reg       <= '0;
            sc_reg        <= '0;
            started_reg   <= 1'b0;
            for (int i = 0; i < MAX_THREADS; i++)
                ts_reg[i] <= TS_UNUSED;
            for (int i = 0; i < MAX_SEMS; i++)
            begin
                cnt_reg[i]  <= '0;
                init_reg[i] <= '0;
                wqh_reg[i]  <= '0;
                wqc_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rq_head_reg   <= rq_head_next;
            rq_count_reg  <= rq_count_next;
            running_reg   <= running_next;
            ntn_reg       <= ntn_next;
            sv_reg        <= sv_next;
            nsn_reg       <= nsn_next;
            sc_reg        <= sc_next;
            started_reg   <= started_next;
            ts_reg        <= ts_next;
            cnt_reg       <= cnt_next;
            init_reg      <= init_next;
            wqh_reg       <= wqh_next;
            wqc_reg       <= wqc_next;
        end
    end

endmodule

@@ design/rrts_checker.sv @@
module rrts_checker
    import rrts_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [3:0] new_thread_id,
    input logic [3:0] running_thread
);

    // pending result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(running_thread)
                                    && $stable(status))
        else $error("result changed while stalled");

    // empty run queue always hands back the main thread
    a_empty_main: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> running_thread == 4'd0)
        else $error("empty queue but a thread runs");

    // a new id comes only with success, and ids begin at two
    a_tid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && new_thread_id != 4'd0 |-> status == ST_OK
                                               && new_thread_id != 4'd1)
        else $error("bad thread id on create");

endmodule

bind round_robin_thread_scheduler rrts_checker u_rrts_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .new_thread_id  (new_thread_id),
    .running_thread (running_thread)
);

@@ bench/round_robin_thread_scheduler_tb.sv @@
`timescale 1ns / 100ps

module round_robin_thread_scheduler_tb;
    import rrts_pkg::*;

    // Expected-result store plus an independent model of the scheduler state
    class sched_scoreboard;
        logic [19:0] quantum;
        logic [3:0]  runq [MAX_THREADS];
        int          rq_head;
        int          rq_count;
        ts_t         tstate [MAX_THREADS];
        logic [3:0]  cur_tid;
        int          last_tid;
        int          sem_cnt [MAX_SEMS];
        int          sem_init [MAX_SEMS];
        bit          sem_live [MAX_SEMS];
        int          next_sid;
        logic [3:0]  waitq [MAX_SEMS][MAX_THREADS];
        int          wq_head [MAX_SEMS];
        int          wq_cnt [MAX_SEMS];
        int          slice;
        bit          started;
        res_t        pending_res [$];
        int          errors;
        int          n_req;
        int          n_res;
        int          n_switch;

        function new();
            quantum  = QUANTUM_RESET;
            rq_head  = 0;
            rq_count = 0;
            foreach (tstate[i]) tstate[i] = TS_UNUSED;
            cur_tid  = 0;
            last_tid = 1;
            foreach (sem_cnt[i])
            begin
                sem_cnt[i]  = 0;
                sem_init[i] = 0;
                sem_live[i] = 0;
                wq_head[i]  = 0;
                wq_cnt[i]   = 0;
            end
            next_sid = 0;
            slice    = 0;
            started  = 0;
            errors   = 0;
            n_req    = 0;
            n_res    = 0;
            n_switch = 0;
        endfunction

        function void rq_push(logic [3:0] id);
            runq[(rq_head + rq_count) % MAX_THREADS] = id;
            rq_count++;
        endfunction

        function void rq_pop();
            rq_head = (rq_head + 1) % MAX_THREADS;
            rq_count--;
        endfunction

        function void pick_next(bit rotate);
            logic [3:0] id;
            while (rq_count > 0 && tstate[runq[rq_head]] == TS_EXIT) rq_pop();
            if (rq_count == 0)
            begin
                cur_tid = 0;
                return;
            end
            if (rotate)
            begin
                id = runq[rq_head];
                rq_pop();
                rq_push(id);
            end
            cur_tid = runq[rq_head];
        endfunction

        function int pending();
            return pending_res.size();
        endfunction

        function void note_request(logic [3:0] op, logic [15:0] stk, logic [2:0] s,
                                   logic [6:0] init);
            res_t       r;
            logic [3:0] prev;
            logic [3:0] tid;
            bit         live;
            int         cnt;
            r = '0;
            r.status = ST_OK;
            cnt = 0;
            prev = cur_tid;
            live = sem_live[s];
            n_req++;
            case (op)
                OP_START:
                begin
                    if (started) r.status = ST_REFUSED;
                    else
                    begin
                        started = 1;
                        slice = 0;
                        pick_next(0);
                        if (rq_count == 0) r.status = ST_EMPTY;
                    end
                end
                OP_TICK:
                begin
                    if (started)
                    begin
                        slice++;
                        if (slice >= quantum)
                        begin
                            slice = 0;
                            pick_next(1);
                        end
                    end
                end
                OP_CREATE:
                begin
                    if (stk > STACK_LIMIT || last_tid + 1 >= MAX_THREADS ||
                        rq_count >= MAX_THREADS)
                        r.status = ST_REFUSED;
                    else
                    begin
                        last_tid++;
                        r.tid = last_tid[3:0];
                        tstate[last_tid] = TS_READY;
                        rq_push(last_tid[3:0]);
                    end
                end
                OP_EXIT:
                begin
                    if (cur_tid == 0) r.status = ST_REFUSED;
                    else
                    begin
                        tstate[cur_tid] = TS_EXIT;
                        pick_next(0);
                    end
                end
                OP_SEM_NEW:
                begin
                    if (next_sid >= MAX_SEMS) r.status = ST_REFUSED;
                    else
                    begin
                        r.sid = next_sid[2:0];
                        sem_live[next_sid] = 1;
                        sem_cnt[next_sid]  = init;
                        sem_init[next_sid] = init;
                        wq_head[next_sid]  = 0;
                        wq_cnt[next_sid]   = 0;
                        next_sid++;
                        cnt = init;
                    end
                end
                OP_WAIT:
                begin
                    if (!live) r.status = ST_REFUSED;
                    else
                    begin
                        if (sem_cnt[s] > 0) sem_cnt[s]--;
                        else if (cur_tid == 0 || wq_cnt[s] >= MAX_THREADS)
                            r.status = ST_REFUSED;
                        else
                        begin
                            sem_cnt[s]--;
                            waitq[s][(wq_head[s] + wq_cnt[s]) % MAX_THREADS] = cur_tid;
                            wq_cnt[s]++;
                            tstate[cur_tid] = TS_WAIT;
                            if (rq_count > 0 && runq[rq_head] == cur_tid) rq_pop();
                            pick_next(0);
                        end
                        cnt = sem_cnt[s];
                    end
                end
                OP_SIGNAL:
                begin
                    if (!live) r.status = ST_REFUSED;
                    else
                    begin
                        if (sem_cnt[s] >= COUNT_TOP) r.status = ST_REFUSED;
                        else
                        begin
                            sem_cnt[s]++;
                            if (sem_cnt[s] <= 0 && wq_cnt[s] > 0 && rq_count < MAX_THREADS)
                            begin
                                tid = waitq[s][wq_head[s]];
                                wq_head[s] = (wq_head[s] + 1) % MAX_THREADS;
                                wq_cnt[s]--;
                                tstate[tid] = TS_READY;
                                rq_push(tid);
                            end
                        end
                        cnt = sem_cnt[s];
                    end
                end
                OP_DESTROY:
                begin
                    if (!live) r.status = ST_REFUSED;
                    else
                    begin
                        cnt = sem_cnt[s];
                        if (wq_cnt[s] > 0) r.status = ST_REFUSED;
                        else
                        begin
                            if (sem_cnt[s] != sem_init[s]) r.status = ST_MISMATCH;
                            sem_live[s] = 0;
                            sem_cnt[s]  = 0;
                            sem_init[s] = 0;
                        end
                    end
                end
                OP_QUERY:
                begin
                    if (!live) r.status = ST_REFUSED;
                    else cnt = sem_cnt[s];
                end
                default: r.status = ST_REFUSED;
            endcase
            r.count    = cnt[7:0];
            r.running  = cur_tid;
            r.switched = (cur_tid != prev);
            pending_res.push_back(r);
        endfunction

        function void check_result(res_t got);
            res_t exp_r;
            n_res++;
            if (pending_res.size() == 0)
            begin
                $error("result transaction with nothing expected");
                errors++;
                return;
            end
            exp_r = pending_res.pop_front();
            if (got.switched) n_switch++;
            if (got.status !== exp_r.status)
            begin
                $error("status: expected %0d, got %0d", exp_r.status, got.status);
                errors++;
            end
            if (got.tid !== exp_r.tid)
            begin
                $error("new_thread_id: expected %0d, got %0d", exp_r.tid, got.tid);
                errors++;
            end
            if (got.sid !== exp_r.sid)
            begin
                $error("new_sem_id: expected %0d, got %0d", exp_r.sid, got.sid);
                errors++;
            end
            if (got.count !== exp_r.count)
            begin
                $error("sem_count: expected %0d, got %0d", exp_r.count, got.count);
                errors++;
            end
            if (got.running !== exp_r.running)
            begin
                $error("running_thread: expected %0d, got %0d", exp_r.running, got.running);
                errors++;
            end
            if (got.switched !== exp_r.switched)
            begin
                $error("switched: expected %0d, got %0d", exp_r.switched, got.switched);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [1:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_ready;
    logic [3:0]        req_type;
    logic [15:0]       stack_size;
    logic [2:0]        sem_index;
    logic [6:0]        sem_init_value;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        status;
    logic [3:0]        new_thread_id;
    logic [2:0]        new_sem_id;
    logic signed [7:0] sem_count;
    logic [3:0]        running_thread;
    logic              switched;

    sched_scoreboard sb;
    bit              idle_en;
    int              holdoff_cycles;
    int              cfg_errors;

    round_robin_thread_scheduler dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .stack_size     (stack_size),
        .sem_index      (sem_index),
        .sem_init_value (sem_init_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .new_thread_id  (new_thread_id),
        .new_sem_id     (new_sem_id),
        .sem_count      (sem_count),
        .running_thread (running_thread),
        .switched       (switched)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: samples at the rising edge, changes out_ready at the falling edge
    initial
    begin
        int   stall_left;
        res_t got;
        stall_left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.status   = st_t'(status);
                got.tid      = new_thread_id;
                got.sid      = new_sem_id;
                got.count    = sem_count;
                got.running  = running_thread;
                got.switched = switched;
                sb.check_result(got);
            end
            @(negedge clk);
            if (holdoff_cycles > 0)
            begin
                holdoff_cycles--;
                out_ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready = 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                out_ready = 1'b0;
            end
            else
                out_ready = 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(logic [3:0] op, logic [15:0] stk, logic [2:0] s,
                                logic [6:0] init);
        int gap;
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       = 1'b1;
        req_type       = op;
        stack_size     = stk;
        sem_index      = s;
        sem_init_value = init;
        forever
        begin
            @(posedge clk);
            if (in_ready) break;
        end
        sb.note_request(op, stk, s, init);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic apb_access(logic wr, logic [31:0] data, output logic [31:0] rd);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = 2'd0;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        forever
        begin
            @(posedge clk);
            if (pready) break;
        end
        rd = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_quantum(logic [19:0] q);
        logic [31:0] rd;
        wait_drained();
        apb_access(1'b1, {12'($urandom_range(0, 4095)), q}, rd);
        sb.quantum = q;
        apb_access(1'b0, 32'd0, rd);
        if (rd[19:0] !== q)
        begin
            $error("quantum_ticks: expected %0d, got %0d", q, rd[19:0]);
            cfg_errors++;
        end
    endtask

    task automatic random_request();
        int         pick;
        logic [3:0] op;
        logic [15:0] stk;
        pick = $urandom_range(0, 99);
        if (pick < 35) op = OP_TICK;
        else if (pick < 45) op = OP_CREATE;
        else if (pick < 52) op = OP_EXIT;
        else if (pick < 57) op = OP_SEM_NEW;
        else if (pick < 70) op = OP_WAIT;
        else if (pick < 84) op = OP_SIGNAL;
        else if (pick < 88) op = OP_DESTROY;
        else if (pick < 95) op = OP_QUERY;
        else if (pick < 97) op = OP_START;
        else op = 4'($urandom_range(OP_BAD, 15));
        if ($urandom_range(0, 9) == 0) stk = 16'($urandom);
        else stk = 16'($urandom_range(0, STACK_LIMIT));
        send_request(op, stk, 3'($urandom), 7'($urandom));
    endtask

    initial
    begin
        sb = new();
        idle_en = 1'b1;
        holdoff_cycles = 0;
        cfg_errors = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        req_type = '0;
        stack_size = '0;
        sem_index = '0;
        sem_init_value = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        repeat (40) @(negedge clk);

        // directed: start on empty queue, stack limits, semaphore corner cases
        send_request(OP_TICK, 16'd0, 3'd0, 7'd0);
        send_request(OP_START, 16'd0, 3'd0, 7'd0);
        send_request(OP_START, 16'd0, 3'd0, 7'd0);
        send_request(OP_EXIT, 16'd0, 3'd0, 7'd0);
        send_request(OP_CREATE, 16'd0, 3'd0, 7'd0);
        send_request(OP_CREATE, 16'd16384, 3'd0, 7'd0);
        send_request(OP_CREATE, 16'd16385, 3'd0, 7'd0);
        send_request(OP_CREATE, 16'hFFFF, 3'd7, 7'h7F);
        send_request(OP_SEM_NEW, 16'd0, 3'd0, 7'd0);
        send_request(OP_SEM_NEW, 16'd0, 3'd0, 7'd127);
        send_request(OP_SIGNAL, 16'd0, 3'd1, 7'd0);
        send_request(OP_QUERY, 16'd0, 3'd1, 7'd0);
        send_request(OP_WAIT, 16'd0, 3'd0, 7'd0);
        send_request(OP_QUERY, 16'd0, 3'd7, 7'd0);
        send_request(OP_DESTROY, 16'd0, 3'd0, 7'd0);
        send_request(OP_WAIT, 16'd0, 3'd0, 7'd0);
        send_request(OP_DESTROY, 16'd0, 3'd1, 7'd0);
        send_request(OP_SIGNAL, 16'd0, 3'd0, 7'd0);
        send_request(OP_DESTROY, 16'd0, 3'd0, 7'd0);
        send_request(OP_EXIT, 16'd0, 3'd0, 7'd0);
        send_request(OP_EXIT, 16'd0, 3'd0, 7'd0);
        send_request(4'd9, 16'd0, 3'd0, 7'd0);
        send_request(4'd15, 16'd0, 3'd0, 7'd0);
        send_request(OP_TICK, 16'd0, 3'd0, 7'd0);

        set_quantum(20'd3);
        repeat (400) random_request();

        // receiver holds off while requests keep coming, so the input stalls
        holdoff_cycles = 300;
        repeat (20) random_request();

        set_quantum(20'd1);
        repeat (350) random_request();

        set_quantum(20'd0);
        repeat (60) random_request();

        // sender pauses until every outstanding result is back
        wait_drained();
        set_quantum(20'hFFFFF);
        repeat (150) random_request();

        set_quantum(20'd2);
        idle_en = 1'b0;
        repeat (350) random_request();

        wait_drained();
        repeat (50) @(negedge clk);
        $display("covered %0d requests and %0d results, %0d thread switches",
                 sb.n_req, sb.n_res, sb.n_switch);
        $display("quantum settings 1000, 3, 1, 0, max and 2; stalls on both sides");
        if (sb.errors == 0 && cfg_errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule
